FILE: rtl/core/crs_pkg.sv
package crs_pkg;

  // Default widths of the internal counters
  localparam int POSITION_BITS_DEF = 40;
  localparam int COLUMN_BITS_DEF   = 16;

  // Fixed field widths of the result item
  localparam int ROW_NUM_W   = 32;
  localparam int ROW_START_W = 40;
  localparam int COL_CNT_W   = 16;
  localparam int EXP_COL_W   = 16;

  localparam logic [EXP_COL_W-1:0] EXP_COL_RESET = 16'd1;

  // Input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  // Result kinds
  localparam logic KIND_ROW     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Characters that steer the scan
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } crs_in_t;

  typedef struct packed {
    logic                   kind;
    logic [ROW_NUM_W-1:0]   row_number;
    logic [ROW_START_W-1:0] row_start;
    logic [COL_CNT_W-1:0]   column_count;
    logic                   mismatch;
    logic                   last;
  } crs_result_t;

  // Results produced by one item, in delivery order
  typedef struct packed {
    logic [1:0]  cnt;
    crs_result_t r0;
    crs_result_t r1;
  } crs_push_t;

endpackage

FILE: rtl/core/csv_row_offset_scanner.sv
// Flow: an accepted item is registered in the input register, scanned into a
//   two-entry result queue once all its results fit; the queue head is then offered.
// Throughput: one byte per cycle while out_stall is low; an end-of-file item that
//   flushes a pending row makes two results, so it and the next item may wait for room.
// Reset (rst_n low, synchronous): empties input register and queue, clears scan
//   state, sets expected_columns to 1.
module csv_row_offset_scanner #(
  parameter int POSITION_BITS = crs_pkg::POSITION_BITS_DEF,
  parameter int COLUMN_BITS   = crs_pkg::COLUMN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_vld,
  output logic                          in_stall,
  input  crs_pkg::crs_in_t              in_item,
  // result channel
  output logic                          out_vld,
  input  logic                          out_stall,
  output crs_pkg::crs_result_t          out_item,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [crs_pkg::EXP_COL_W-1:0] cfg_wr_data
);

  // Input register: holds one accepted item until the queue has room for
  // all of its results. Stall depends only on registered state, so there
  // is no combinational path from out_stall to in_stall.
  logic                          in_vld_r, in_vld_nxt;
  crs_pkg::crs_in_t              in_item_r;
  logic [crs_pkg::EXP_COL_W-1:0] exp_cols_r;

  crs_pkg::crs_push_t push_raw;
  crs_pkg::crs_push_t push_q;
  logic [1:0]         free;
  logic               consume;
  logic               load;

  // Process the held item once every result it makes fits in the queue.
  assign consume  = in_vld_r && (push_raw.cnt <= free);
  assign in_stall = in_vld_r && !consume;
  assign load     = in_vld && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (load) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
    // gate the push so an idle or stalled stage writes nothing
    push_q     = push_raw;
    push_q.cnt = consume ? push_raw.cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      exp_cols_r <= crs_pkg::EXP_COL_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_wr_en) begin
        exp_cols_r <= cfg_wr_data;
      end
    end
  end

  // Scan state and per-byte decision: quote toggle, comma count, row end on LF/CR,
  // LF-after-CR swallow, halt on a column mismatch, end-of-file flush and summary.
  crs_scan #(
    .POSITION_BITS (POSITION_BITS),
    .COLUMN_BITS   (COLUMN_BITS)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .expected_columns (exp_cols_r),
    .item             (in_item_r),
    .fire             (consume),
    .push             (push_raw)
  );

  // Result queue: separates the scan from the consumer so the next byte is
  // taken while a finished result still waits.
  crs_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_q),
    .free      (free),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && (out_item.kind == crs_pkg::KIND_SUMMARY) |-> out_item.last)
    else $error("summary item without last");

  a_row_after_eof_flush: assert property (@(posedge clk) disable iff (!rst_n)
    consume && (push_q.cnt == 2'd2) |-> (push_q.r0.kind == crs_pkg::KIND_ROW) && !push_q.r0.last)
    else $error("flushed row malformed");

endmodule

FILE: rtl/core/crs_scan.sv
module crs_scan #(
  parameter int POSITION_BITS = crs_pkg::POSITION_BITS_DEF,
  parameter int COLUMN_BITS   = crs_pkg::COLUMN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [crs_pkg::EXP_COL_W-1:0]  expected_columns,
  input  crs_pkg::crs_in_t               item,
  input  logic                           fire,
  output crs_pkg::crs_push_t             push
);

  localparam int CMP_W = (COLUMN_BITS > crs_pkg::COL_CNT_W) ? COLUMN_BITS : crs_pkg::COL_CNT_W;
  localparam int EXT_W = (POSITION_BITS > crs_pkg::ROW_START_W) ?
                         POSITION_BITS : crs_pkg::ROW_START_W;
  localparam logic [COLUMN_BITS-1:0]   COL_MAX = {COLUMN_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0]   COL_ONE = COLUMN_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [CMP_W-1:0]         CLAMP   = CMP_W'({crs_pkg::COL_CNT_W{1'b1}});

  logic                           in_quotes_r, in_quotes_nxt;
  logic                           skip_lf_r, skip_lf_nxt;
  logic [POSITION_BITS-1:0]       pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]       start_r, start_nxt;
  logic [COLUMN_BITS-1:0]         comma_r, comma_nxt;
  logic [crs_pkg::ROW_NUM_W-1:0]  rows_r, rows_nxt;
  logic                           halted_r, halted_nxt;

  logic [POSITION_BITS-1:0]       pos_inc;
  logic [crs_pkg::ROW_NUM_W-1:0]  rows_inc;
  logic [COLUMN_BITS-1:0]         cols;
  logic [CMP_W-1:0]               cols_cmp;
  logic [EXT_W-1:0]               start_ext, pos_ext;
  logic                           row_mis;
  logic                           is_data;
  logic                           lf_swallow;
  logic                           row_end;
  logic                           flush;
  logic [7:0]                     c;
  crs_pkg::crs_result_t           row_rec, sum_rec;

  always_comb begin
    c          = item.data_byte;
    is_data    = (item.cmd == crs_pkg::CMD_DATA);
    pos_inc    = pos_r + POS_ONE;
    rows_inc   = rows_r + 32'd1;
    cols       = (comma_r == COL_MAX) ? COL_MAX : comma_r + COL_ONE;
    cols_cmp   = CMP_W'(cols);
    row_mis    = (cols_cmp != CMP_W'(expected_columns));
    start_ext  = EXT_W'(start_r);
    pos_ext    = EXT_W'(pos_r);
    lf_swallow = skip_lf_r && (c == crs_pkg::CH_LF);
    row_end    = is_data && !halted_r && !lf_swallow && !in_quotes_r &&
                 ((c == crs_pkg::CH_LF) || (c == crs_pkg::CH_CR));
    flush      = !halted_r && (pos_r != start_r);

    row_rec.kind         = crs_pkg::KIND_ROW;
    row_rec.row_number   = rows_inc;
    row_rec.row_start    = start_ext[crs_pkg::ROW_START_W-1:0];
    row_rec.column_count = (cols_cmp > CLAMP) ? {crs_pkg::COL_CNT_W{1'b1}} :
                           cols_cmp[crs_pkg::COL_CNT_W-1:0];
    row_rec.mismatch     = row_mis;
    row_rec.last         = is_data;

    sum_rec.kind         = crs_pkg::KIND_SUMMARY;
    sum_rec.row_number   = flush ? rows_inc : rows_r;
    sum_rec.row_start    = pos_ext[crs_pkg::ROW_START_W-1:0];
    sum_rec.column_count = '0;
    sum_rec.mismatch     = halted_r || (flush && row_mis);
    sum_rec.last         = 1'b1;

    if (is_data) begin
      push.cnt = {1'b0, row_end};
      push.r0  = row_rec;
      push.r1  = sum_rec;
    end else begin
      push.cnt = flush ? 2'd2 : 2'd1;
      push.r0  = flush ? row_rec : sum_rec;
      push.r1  = sum_rec;
    end
  end

  always_comb begin
    in_quotes_nxt = in_quotes_r;
    skip_lf_nxt   = skip_lf_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    comma_nxt     = comma_r;
    rows_nxt      = rows_r;
    halted_nxt    = halted_r;
    if (fire) begin
      if (!is_data) begin
        // end of file: re-arm for the next file
        in_quotes_nxt = 1'b0;
        skip_lf_nxt   = 1'b0;
        pos_nxt       = '0;
        start_nxt     = '0;
        comma_nxt     = '0;
        rows_nxt      = '0;
        halted_nxt    = 1'b0;
      end else if (!halted_r) begin
        pos_nxt     = pos_inc;
        skip_lf_nxt = 1'b0;
        if (lf_swallow) begin
          start_nxt = pos_inc;
        end else if (c == crs_pkg::CH_QUOTE) begin
          in_quotes_nxt = !in_quotes_r;
        end else if (!in_quotes_r) begin
          if (c == crs_pkg::CH_COMMA) begin
            if (comma_r != COL_MAX) begin
              comma_nxt = comma_r + COL_ONE;
            end
          end else if (row_end) begin
            rows_nxt    = rows_inc;
            comma_nxt   = '0;
            start_nxt   = pos_inc;
            halted_nxt  = row_mis;
            skip_lf_nxt = (c == crs_pkg::CH_CR) && !row_mis;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      skip_lf_r   <= 1'b0;
      pos_r       <= '0;
      start_r     <= '0;
      comma_r     <= '0;
      rows_r      <= '0;
      halted_r    <= 1'b0;
    end else begin
      in_quotes_r <= in_quotes_nxt;
      skip_lf_r   <= skip_lf_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      comma_r     <= comma_nxt;
      rows_r      <= rows_nxt;
      halted_r    <= halted_nxt;
    end
  end

  a_eof_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.cmd == crs_pkg::CMD_EOF) |=> (pos_r == '0) && (rows_r == '0) && !halted_r)
    else $error("scan state not cleared after end of file");

  a_halted_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    fire && halted_r && (item.cmd == crs_pkg::CMD_DATA) |=> $stable(pos_r) && $stable(rows_r))
    else $error("data byte changed state while halted");

  a_start_behind: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !skip_lf_r)
    else $error("CR skip armed after a mismatch");

endmodule

FILE: rtl/core/crs_rq.sv
module crs_rq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crs_pkg::crs_push_t    push,
  output logic [1:0]            free,
  output logic                  out_vld,
  input  logic                  out_stall,
  output crs_pkg::crs_result_t  out_item
);

  crs_pkg::crs_result_t slot_r [2];
  crs_pkg::crs_result_t slot_nxt [2];
  logic [1:0]           cnt_r, cnt_nxt;
  logic [1:0]           rem;
  logic                 pop;

  assign out_vld  = (cnt_r != 2'd0);
  assign out_item = slot_r[0];
  assign free     = 2'd2 - cnt_r;
  assign pop      = out_vld && !out_stall;

  always_comb begin
    rem         = cnt_r - {1'b0, pop};
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = slot_r[1];
    // append behind whatever stays
    if (rem == 2'd0) begin
      if (push.cnt != 2'd0) begin
        slot_nxt[0] = push.r0;
      end
      if (push.cnt == 2'd2) begin
        slot_nxt[1] = push.r1;
      end
    end else if (push.cnt != 2'd0) begin
      slot_nxt[1] = push.r0;
    end
    cnt_nxt = rem + push.cnt;
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt <= free)
    else $error("result queue overflow");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall && (cnt_r == 2'd2) |=> (cnt_r == 2'd2))
    else $error("full queue lost an entry while stalled");

endmodule
